>>> design/frx_pkg.sv
// Shared types, constants and helpers for the frame receiver.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package frx_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned INDEX_W = 9;
	localparam int unsigned SUM_W   = 16;
	localparam int unsigned CFG_IDX_W = 1;

	// header bytes ahead of the payload plus the trailing checksum byte
	localparam logic [INDEX_W-1:0] FRAME_OVERHEAD = 9'd3;

	localparam logic [BYTE_W-1:0] FRAME_ID_RESET    = 8'h00;
	localparam logic [BYTE_W-1:0] MAX_PAYLOAD_RESET = 8'hff;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ID    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 1'b1;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef enum logic [2:0] {
		ST_INCOMPLETE = 3'd0,
		ST_COMPLETE   = 3'd1,
		ST_CHECKSUM   = 3'd2,
		ST_LENGTH     = 3'd3,
		ST_TIMEOUT    = 3'd4
	} status_t;

	typedef struct packed {
		logic [BYTE_W-1:0] frame_id;
		logic [BYTE_W-1:0] max_payload;
	} frx_cfg_t;

	typedef struct packed {
		status_t            status;
		logic               store_valid;
		logic [BYTE_W-1:0]  store_byte;
		logic [INDEX_W-1:0] store_index;
		logic [BYTE_W-1:0]  frame_length;
	} frx_result_t;

	// Fold a 16-bit sum twice with end-around carry down to one byte.
	function automatic logic [BYTE_W-1:0] fold_sum(input logic [SUM_W-1:0] s);
		logic [BYTE_W:0] t;
		logic [BYTE_W:0] u;
		t = {1'b0, s[SUM_W-1:BYTE_W]} + {1'b0, s[BYTE_W-1:0]};
		u = {{(BYTE_W){1'b0}}, t[BYTE_W]} + {1'b0, t[BYTE_W-1:0]};
		return u[BYTE_W-1:0];
	endfunction

endpackage

`default_nettype wire

>>> design/frx_in_if.sv
// Input channel of the frame receiver: valid/ready plus one received item.
// Depends on frx_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface frx_in_if import frx_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              operation;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output operation, output rx_byte, input ready);
	modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

`default_nettype wire

>>> design/frx_out_if.sv
// Output channel of the frame receiver: valid/ready plus one status item.
// Depends on frx_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface frx_out_if import frx_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [2:0]         status;
	logic               store_valid;
	logic [BYTE_W-1:0]  store_byte;
	logic [INDEX_W-1:0] store_index;
	logic [BYTE_W-1:0]  frame_length;

	modport source (output valid, output status, output store_valid, output store_byte,
		output store_index, output frame_length, input ready);
	modport sink   (input valid, input status, input store_valid, input store_byte,
		input store_index, input frame_length, output ready);
endinterface

`default_nettype wire

>>> design/frame_receiver_with_timeout.sv
// Length-prefixed frame receiver with folded-sum checksum and two-tick timeout.
// Depends on frx_pkg, frx_in_if, frx_out_if, frx_cfg_regs and frx_step.
`timescale 1ns / 1ps
`default_nettype none

// Usage: every transfer on item_in is either one received byte or one timer
// tick, and gives exactly one transfer on result_out, in order. Frames are
// id, length, payload, checksum; each byte that belongs to a frame buffer is
// reported with its buffer position instead of being stored. The block takes
// one item per cycle while result_out is not stalled; a result passes through
// one input register and one result register. The per-item parse state (byte
// count, running sum, flags) updates in the cycle that loads the item's result,
// which sets the one-item-per-cycle rate. Both channels stall freely: a full
// result register not taken holds the input register, which drops ready if full.
// Write cfg_index/cfg_data with cfg_wr_en only while no item is in flight.
module frame_receiver_with_timeout import frx_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [BYTE_W-1:0]    cfg_data,
	frx_in_if.sink                    item_in,
	frx_out_if.source                 result_out
);

	frx_cfg_t    cfg;
	frx_result_t step_result;
	frx_result_t result_s2;

	logic              valid_s1;
	logic              op_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              valid_s2;

	logic adv_s2;  // result register may load
	logic adv_s1;  // item in the input register is processed this cycle

	// result register frees up when empty or being taken
	assign adv_s2 = !valid_s2 || result_out.ready;
	assign adv_s1 = valid_s1 && adv_s2;
	assign item_in.ready = !valid_s1 || adv_s2;

	frx_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	frx_step u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (adv_s1),
		.operation (op_s1),
		.rx_byte   (byte_s1),
		.cfg       (cfg),
		.result    (step_result)
	);

	// Input register: load on every input transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_in.ready) begin
			valid_s1 <= item_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_in.valid && item_in.ready) begin
			op_s1   <= item_in.operation;
			byte_s1 <= item_in.rx_byte;
		end
	end

	// Result register: hold while the sink stalls, advance otherwise.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			result_s2 <= step_result;
		end
	end

	assign result_out.valid        = valid_s2;
	assign result_out.status       = result_s2.status;
	assign result_out.store_valid  = result_s2.store_valid;
	assign result_out.store_byte   = result_s2.store_byte;
	assign result_out.store_index  = result_s2.store_index;
	assign result_out.frame_length = result_s2.frame_length;

endmodule

`default_nettype wire

>>> design/frx_cfg_regs.sv
// Configuration registers of the frame receiver (frame id, payload limit).
// Depends on frx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module frx_cfg_regs import frx_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [BYTE_W-1:0]    cfg_data,
	output frx_cfg_t                  cfg
);

	frx_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_id    <= FRAME_ID_RESET;
			cfg_q.max_payload <= MAX_PAYLOAD_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_FRAME_ID:    cfg_q.frame_id    <= cfg_data;
				CFG_MAX_PAYLOAD: cfg_q.max_payload <= cfg_data;
				default:         cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> design/frx_step.sv
// Frame parser state and the per-item step logic that produces one result.
// Depends on frx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module frx_step import frx_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step_en,
	input  wire logic              operation,
	input  wire logic [BYTE_W-1:0] rx_byte,
	input  wire frx_cfg_t          cfg,
	output frx_result_t            result
);

	logic [INDEX_W-1:0] byte_count_q, byte_count_d;
	logic               frame_ok_q, frame_ok_d;
	logic [BYTE_W-1:0]  payload_len_q, payload_len_d;
	logic               tick_seen_q, tick_seen_d;
	logic [SUM_W-1:0]   running_sum_q, running_sum_d;

	logic [INDEX_W-1:0] count_inc;
	logic               frame_end;
	logic [SUM_W-1:0]   sum_add;

	assign count_inc = byte_count_q + 9'd1;
	assign frame_end = (count_inc == ({1'b0, payload_len_q} + FRAME_OVERHEAD));
	assign sum_add   = running_sum_q + {{(SUM_W-BYTE_W){1'b0}}, rx_byte};

	always_comb begin
		byte_count_d       = byte_count_q;
		frame_ok_d         = frame_ok_q;
		payload_len_d      = payload_len_q;
		tick_seen_d        = tick_seen_q;
		running_sum_d      = running_sum_q;
		result.status      = ST_INCOMPLETE;
		result.store_valid = 1'b0;
		result.store_byte  = '0;
		result.store_index = '0;

		if (operation == OP_TICK) begin
			if (byte_count_q != '0) begin
				if (!tick_seen_q) begin
					tick_seen_d = 1'b1;
				end else begin
					byte_count_d  = '0;
					result.status = ST_TIMEOUT;
				end
			end
		end else begin
			tick_seen_d = 1'b0;
			if (byte_count_q == 9'd0) begin
				result.store_valid = 1'b1;
				result.store_byte  = rx_byte;
				byte_count_d       = 9'd1;
				running_sum_d      = {{(SUM_W-BYTE_W){1'b0}}, rx_byte};
				frame_ok_d         = (rx_byte == cfg.frame_id);
				if (rx_byte != cfg.frame_id)
					result.status = ST_CHECKSUM;
			end else if (byte_count_q == 9'd1) begin
				result.store_valid = 1'b1;
				result.store_byte  = rx_byte;
				result.store_index = 9'd1;
				byte_count_d       = 9'd2;
				running_sum_d      = sum_add;
				if (frame_ok_q) begin
					payload_len_d = rx_byte;
					if (rx_byte > cfg.max_payload) begin
						frame_ok_d    = 1'b0;
						result.status = ST_LENGTH;
					end
				end
			end else if (frame_ok_q) begin
				result.store_valid = 1'b1;
				result.store_byte  = rx_byte;
				result.store_index = byte_count_q;
				if (frame_end) begin
					byte_count_d  = '0;
					result.status = (fold_sum(running_sum_q) == rx_byte) ?
						ST_COMPLETE : ST_CHECKSUM;
				end else begin
					byte_count_d  = count_inc;
					running_sum_d = sum_add;
				end
			end else begin
				// skip the rest of a rejected frame by count
				byte_count_d = frame_end ? '0 : count_inc;
			end
		end

		result.frame_length = payload_len_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q  <= '0;
			frame_ok_q    <= 1'b0;
			payload_len_q <= '0;
			tick_seen_q   <= 1'b0;
			running_sum_q <= '0;
		end else if (step_en) begin
			byte_count_q  <= byte_count_d;
			frame_ok_q    <= frame_ok_d;
			payload_len_q <= payload_len_d;
			tick_seen_q   <= tick_seen_d;
			running_sum_q <= running_sum_d;
		end
	end

endmodule

`default_nettype wire

>>> design/frx_checker.sv
// Port-level checks for frame_receiver_with_timeout, bound to the top level.
// Depends on frx_pkg for status codes and widths.
`timescale 1ns / 1ps
`default_nettype none

module frx_checker import frx_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic [2:0]         status,
	input wire logic               store_valid,
	input wire logic [BYTE_W-1:0]  store_byte,
	input wire logic [INDEX_W-1:0] store_index,
	input wire logic [BYTE_W-1:0]  frame_length
);

	// stalled result holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(store_index))
		else $error("result changed while stalled");

	// a complete frame ends on a stored checksum byte past the header
	a_complete_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_COMPLETE |-> store_valid && store_index >= 9'd2)
		else $error("complete status without a stored checksum byte");

	// a timeout carries no stored byte
	a_timeout_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_TIMEOUT |->
			!store_valid && store_byte == '0 && store_index == '0)
		else $error("timeout reported with store data");

	// a length error is reported on the length byte, which becomes frame_length
	a_length_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_LENGTH |->
			store_valid && store_index == 9'd1 && store_byte == frame_length)
		else $error("length error not on the length byte");

endmodule

bind frame_receiver_with_timeout frx_checker u_frx_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (result_out.valid),
	.out_ready    (result_out.ready),
	.status       (result_out.status),
	.store_valid  (result_out.store_valid),
	.store_byte   (result_out.store_byte),
	.store_index  (result_out.store_index),
	.frame_length (result_out.frame_length)
);

`default_nettype wire
